// ===== rtl/pptr_pkg.sv =====
// ----------------------------------------------------------------------------
// pptr_pkg
// Shared constants for the picker point-to-RGB core.
// ----------------------------------------------------------------------------
`default_nettype none

package pptr_pkg;

    localparam int unsigned COORD_W = 10;
    localparam int unsigned CHAN_W  = 8;

    localparam logic [COORD_W-1:0] WIDTH_RESET  = 10'd100;
    localparam logic [COORD_W-1:0] HEIGHT_RESET = 10'd150;

    localparam logic [0:0] REG_AREA_WIDTH  = 1'b0;
    localparam logic [0:0] REG_AREA_HEIGHT = 1'b1;

    localparam logic [2:0] SECT_0 = 3'd0;
    localparam logic [2:0] SECT_1 = 3'd1;
    localparam logic [2:0] SECT_2 = 3'd2;
    localparam logic [2:0] SECT_3 = 3'd3;
    localparam logic [2:0] SECT_4 = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/pptr_div.sv =====
// ----------------------------------------------------------------------------
// pptr_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module pptr_div #(
    parameter int unsigned NUM_W = 44,
    parameter int unsigned DEN_W = 11,
    parameter int unsigned SB_W  = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [SB_W-1:0]  i_sb,
    output logic                  o_valid,
    output logic [NUM_W-1:0]      o_quot,
    output logic [SB_W-1:0]       o_sb
);

    // Each stage shifts in one numerator bit and makes one quotient bit.
    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic             w_v;
        logic [NUM_W-1:0] w_num;
        logic [DEN_W-1:0] w_rem;
        logic [DEN_W-1:0] w_den;
        logic [SB_W-1:0]  w_sb;
        logic [DEN_W:0]   n_trial;
        logic             n_ge;
        logic             r_v;
        logic [NUM_W-1:0] r_num;
        logic [SB_W-1:0]  r_sb;

        if (k == 0) begin : g_head
            assign w_v   = i_valid;
            assign w_num = i_num;
            assign w_rem = '0;
            assign w_den = i_den;
            assign w_sb  = i_sb;
        end else begin : g_link
            assign w_v   = g_stage[k-1].r_v;
            assign w_num = g_stage[k-1].r_num;
            assign w_rem = g_stage[k-1].g_carry.r_rem;
            assign w_den = g_stage[k-1].g_carry.r_den;
            assign w_sb  = g_stage[k-1].r_sb;
        end

        assign n_trial = {w_rem, w_num[NUM_W-1]};
        assign n_ge    = n_trial >= {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num <= {w_num[NUM_W-2:0], n_ge};
                r_sb  <= w_sb;
            end
        end

        // The last stage needs no remainder or divisor.
        if (k < NUM_W - 1) begin : g_carry
            logic [DEN_W-1:0] r_rem;
            logic [DEN_W-1:0] r_den;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= n_ge ? DEN_W'(n_trial - {1'b0, w_den})
                                  : n_trial[DEN_W-1:0];
                    r_den <= w_den;
                end
            end
        end
    end

    assign o_valid = g_stage[NUM_W-1].r_v;
    assign o_quot  = g_stage[NUM_W-1].r_num;
    assign o_sb    = g_stage[NUM_W-1].r_sb;

endmodule

`default_nettype wire

// ===== rtl/picker_point_to_rgb_core.sv =====
// ----------------------------------------------------------------------------
// picker_point_to_rgb_core
// Maps a point of an HSV picker gradient to its RGB color, fully pipelined.
// ----------------------------------------------------------------------------
// Stages: 1 setup, FRAC_BITS+13 divider stages, 5 multiply/assemble stages
//   and the output register; the setup register loads at the accepting edge.
// Throughput: one request per cycle unless stalled; dividers set the depth.
// A stall freezes the whole pipe; an output skid stage keeps tready registered.
// Reset (synchronous, active low) empties the pipe and restores W=100, H=150.
`default_nettype none

module picker_point_to_rgb_core
    import pptr_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // pixel_x[9:0], pixel_y[19:10]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // red, green, blue, out_of_range[24]
);

    localparam int unsigned FB   = FRAC_BITS;
    localparam int unsigned NW   = FB + 13;   // numerator width (6x < 2^13)
    localparam int unsigned FXW  = FB + 1;    // values up to 1.0
    localparam int unsigned SBW  = 4;         // oor, lo, h0, vneg
    localparam logic [FXW-1:0] ONE = FXW'(1) << FB;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [9:0] r_w, r_h;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= WIDTH_RESET;
            r_h <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_AREA_WIDTH:  r_w <= i_cfg_data;
                REG_AREA_HEIGHT: r_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: the pipe moves unless the skid stage is full.
    // ------------------------------------------------------------------
    logic r_skid_v;
    logic w_en;
    assign w_en          = !r_skid_v;
    assign s_axis_tready = w_en;

    logic [9:0] w_x, w_y;
    assign w_x = s_axis_tdata[9:0];
    assign w_y = s_axis_tdata[19:10];

    // Stage 0: range check and setup of the three divisions.
    logic        r0_v, r0_oor, r0_lo, r0_h0, r0_vneg;
    logic [10:0] r0_ya, r0_yb, r0_den_sv, r0_w;
    logic [12:0] r0_x6;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_v <= 1'b0;
        else if (w_en) r0_v <= s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        logic [9:0] v_half;
        v_half = r_h >> 1;
        if (w_en) begin
            r0_oor    <= (r_w == '0) || (r_h == '0) || (w_x >= r_w) || (w_y >= r_h);
            r0_lo     <= w_y <= v_half;
            r0_h0     <= v_half == '0;
            r0_vneg   <= {v_half, 1'b0} < {1'b0, w_y};
            // y<=half: sat = y/half ; else sat = half/y, val = (2half-y)/y
            r0_ya     <= (w_y <= v_half) ? {1'b0, w_y} : {1'b0, v_half};
            r0_yb     <= {v_half, 1'b0} - {1'b0, w_y};
            r0_den_sv <= (w_y <= v_half) ? {1'b0, v_half} : {1'b0, w_y};
            r0_w      <= {1'b0, r_w};
            r0_x6     <= 13'(w_x) * 13'd6;
        end
    end

    // Three parallel dividers; zero denominators give all-ones, masked later.
    logic            d_v;
    logic [NW-1:0]   q_sat, q_val, q_hue;
    logic [SBW-1:0]  d_sb;
    logic [SBW-1:0]  w_sb_in;
    assign w_sb_in = {r0_oor, r0_lo, r0_h0, r0_vneg};

    pptr_div #(.NUM_W(NW), .DEN_W(11), .SB_W(SBW)) u_div_sat (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r0_v),
        .i_num(NW'(r0_ya) << FB), .i_den(r0_den_sv), .i_sb(w_sb_in),
        .o_valid(d_v), .o_quot(q_sat), .o_sb(d_sb));

    logic d_v_b, d_v_c;
    logic d_sb_b, d_sb_c;
    pptr_div #(.NUM_W(NW), .DEN_W(11), .SB_W(1)) u_div_val (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r0_v),
        .i_num(NW'(r0_yb) << FB), .i_den(r0_den_sv), .i_sb(r0_oor),
        .o_valid(d_v_b), .o_quot(q_val), .o_sb(d_sb_b));

    pptr_div #(.NUM_W(NW), .DEN_W(11), .SB_W(1)) u_div_hue (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r0_v),
        .i_num(NW'(r0_x6) << FB), .i_den(r0_w), .i_sb(r0_oor),
        .o_valid(d_v_c), .o_quot(q_hue), .o_sb(d_sb_c));

    // Stage A: clamp saturation/value, split hue.
    logic           ra_v, ra_oor;
    logic [FXW-1:0] ra_sat, ra_val, ra_frac;
    logic [2:0]     ra_sect;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) ra_v <= 1'b0;
        else if (w_en) ra_v <= d_v & d_v_b & d_v_c;
    end
    always_ff @(posedge i_clk) begin
        logic v_oor, v_lo, v_h0, v_neg;
        {v_oor, v_lo, v_h0, v_neg} = d_sb;
        if (w_en) begin
            ra_oor <= v_oor | d_sb_b | d_sb_c;
            if (v_lo && v_h0) ra_sat <= '0;
            else ra_sat <= (q_sat > NW'(ONE)) ? ONE : q_sat[FXW-1:0];
            if (v_lo) ra_val <= ONE;
            else if (v_neg) ra_val <= '0;
            else ra_val <= (q_val > NW'(ONE)) ? ONE : q_val[FXW-1:0];
            ra_frac <= {1'b0, q_hue[FB-1:0]};
            ra_sect <= 3'(q_hue[NW-1:FB]);
        end
    end

    // fx_mul from the model: saturating shortcut, else truncated product.
    function automatic logic [FXW-1:0] f_mul(input logic [FXW-1:0] a,
                                             input logic [FXW-1:0] b);
        logic [2*FXW-1:0] v_p;
        v_p = a * b;
        if (a >= ONE) return b;
        if (b >= ONE) return a;
        return FXW'(v_p >> FB);
    endfunction

    // Stage B: 1-sat, sat*f and sat*(1-f).
    logic           rb_v, rb_oor;
    logic [FXW-1:0] rb_val, rb_ns, rb_sf, rb_sg;
    logic [2:0]     rb_sect;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rb_v <= 1'b0;
        else if (w_en) rb_v <= ra_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rb_oor  <= ra_oor;
            rb_val  <= ra_val;
            rb_sect <= ra_sect;
            rb_ns   <= ONE - ra_sat;
            rb_sf   <= f_mul(ra_sat, ra_frac);
            rb_sg   <= f_mul(ra_sat, ONE - ra_frac);
        end
    end

    // Stage C: p, q, t.
    logic           rc_v, rc_oor;
    logic [FXW-1:0] rc_val, rc_p, rc_q, rc_t;
    logic [2:0]     rc_sect;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rc_v <= 1'b0;
        else if (w_en) rc_v <= rb_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rc_oor  <= rb_oor;
            rc_val  <= rb_val;
            rc_sect <= rb_sect;
            rc_p    <= f_mul(rb_val, rb_ns);
            rc_q    <= f_mul(rb_val, ONE - rb_sf);
            rc_t    <= f_mul(rb_val, ONE - rb_sg);
        end
    end

    // Stage D: sector select.
    logic           rd_v, rd_oor;
    logic [FXW-1:0] rd_r, rd_g, rd_b;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rd_v <= 1'b0;
        else if (w_en) rd_v <= rc_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rd_oor <= rc_oor;
            case (rc_sect)
                SECT_0:  begin rd_r <= rc_val; rd_g <= rc_t;   rd_b <= rc_p;   end
                SECT_1:  begin rd_r <= rc_q;   rd_g <= rc_val; rd_b <= rc_p;   end
                SECT_2:  begin rd_r <= rc_p;   rd_g <= rc_val; rd_b <= rc_t;   end
                SECT_3:  begin rd_r <= rc_p;   rd_g <= rc_q;   rd_b <= rc_val; end
                SECT_4:  begin rd_r <= rc_t;   rd_g <= rc_p;   rd_b <= rc_val; end
                default: begin rd_r <= rc_val; rd_g <= rc_p;   rd_b <= rc_q;   end
            endcase
        end
    end

    // Scale to bytes: (v*255)>>FB, clamp to 255.
    function automatic logic [7:0] f_byte(input logic [FXW-1:0] v);
        logic [FXW+7:0] v_s;
        logic [8:0]     v_r;
        v_s = ({8'd0, v} << 8) - {8'd0, v};
        v_r = 9'(v_s >> FB);
        return (v_r > 9'd255) ? 8'd255 : v_r[7:0];
    endfunction

    // Stage E: scale to bytes and register.
    logic        re_v;
    logic [31:0] re_data;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) re_v <= 1'b0;
        else if (w_en) re_v <= rd_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            re_data <= rd_oor ? 32'h0100_0000
                              : {8'd0, f_byte(rd_b), f_byte(rd_g), f_byte(rd_r)};
        end
    end

    // Output: primary = r_out, skid catches a result when the sink stalls.
    logic [31:0] r_skid_d;
    logic        r_out_v;
    logic [31:0] r_out_d;
    // Primary output register loads from the pipe; skid holds overflow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (!r_out_v || m_axis_tready) begin
                if (r_skid_v) begin
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out_v <= re_v && w_en;
                end
            end else if (re_v && w_en) begin
                r_skid_v <= 1'b1;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!r_out_v || m_axis_tready) begin
            r_out_d <= r_skid_v ? r_skid_d : re_data;
        end
        if (r_out_v && !m_axis_tready && re_v && w_en) r_skid_d <= re_data;
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_d;

endmodule

`default_nettype wire

// ===== rtl/pptr_checker.sv =====
// ----------------------------------------------------------------------------
// pptr_checker
// Port-level checks for the picker point-to-RGB core.
// ----------------------------------------------------------------------------
`default_nettype none

module pptr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        s_axis_tready
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");

    a_oor_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tdata[23:0] == 24'd0)
        else $error("out of range point not black");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:25] == 7'd0)
        else $error("pad bits set");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipe not empty after reset");

endmodule

bind picker_point_to_rgb_core pptr_checker u_pptr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .s_axis_tready(s_axis_tready)
);

`default_nettype wire

// ===== tb/picker_point_to_rgb_core_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// picker_point_to_rgb_core_checker
// Watches the config port and both streams, predicts the color of every
// accepted point and compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module picker_point_to_rgb_core_checker
    import pptr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_ready,
    input  wire logic [23:0] i_req_data,   // pixel_x[9:0], pixel_y[19:10]
    input  wire logic        i_rsp_valid,
    input  wire logic        i_rsp_ready,
    input  wire logic [31:0] i_rsp_data,   // red, green, blue, out_of_range[24]
    output int               o_fail_count,
    output int               o_pending
);

    localparam int FB = 24;
    localparam logic [63:0] ONE_FX = 64'd1 << FB;

    typedef struct packed {
        logic       out_of_range;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_color;

    logic [COORD_W-1:0] area_w;
    logic [COORD_W-1:0] area_h;
    t_color             color_q[$];

    function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
        if (a >= ONE_FX) return b;
        if (b >= ONE_FX) return a;
        return (a * b) >> FB;
    endfunction

    function automatic logic [7:0] to_byte(logic [63:0] v);
        logic [63:0] r;
        r = (v * 255) >> FB;
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function automatic t_color shade_point(logic [9:0] x, logic [9:0] y,
                                           logic [9:0] w, logic [9:0] h);
        t_color      c;
        logic [63:0] half, sat, val, hue, frac, p, q, t, r, g, b;
        logic [63:0] sector;
        c = '0;
        if (w == 0 || h == 0 || x >= w || y >= h) begin
            c.out_of_range = 1'b1;
            return c;
        end
        half = h / 2;
        if (y <= half) begin
            sat = (half == 0) ? 64'd0 : (64'(y) << FB) / half;
            val = ONE_FX;
        end else begin
            sat = (half << FB) / y;
            // rows below 2*half would run negative: clamp to black
            val = (2 * half >= y) ? ((2 * half - y) << FB) / y : 64'd0;
        end
        if (sat > ONE_FX) sat = ONE_FX;
        if (val > ONE_FX) val = ONE_FX;
        hue    = ((64'd6 * x) << FB) / w;
        sector = hue >> FB;
        frac   = hue & (ONE_FX - 1);
        p = fx_mul(val, ONE_FX - sat);
        q = fx_mul(val, ONE_FX - fx_mul(sat, frac));
        t = fx_mul(val, ONE_FX - fx_mul(sat, ONE_FX - frac));
        case (sector)
            SECT_0:  begin r = val; g = t;   b = p;   end
            SECT_1:  begin r = q;   g = val; b = p;   end
            SECT_2:  begin r = p;   g = val; b = t;   end
            SECT_3:  begin r = p;   g = q;   b = val; end
            SECT_4:  begin r = t;   g = p;   b = val; end
            default: begin r = val; g = p;   b = q;   end
        endcase
        c.red   = to_byte(r);
        c.green = to_byte(g);
        c.blue  = to_byte(b);
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_color got, want;
        if (!i_rst_n) begin
            area_w       = WIDTH_RESET;
            area_h       = HEIGHT_RESET;
            o_fail_count = 0;
            color_q.delete();
        end else begin
            // results first: a request never returns in the cycle it is taken
            if (i_rsp_valid && i_rsp_ready) begin
                got = i_rsp_data[24:0];
                if (color_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, i_rsp_data);
                    o_fail_count++;
                end else begin
                    want = color_q.pop_front();
                    if (got.red !== want.red) begin
                        $display("%0t: red expected %0d actual %0d",
                                 $time, want.red, got.red);
                        o_fail_count++;
                    end
                    if (got.green !== want.green) begin
                        $display("%0t: green expected %0d actual %0d",
                                 $time, want.green, got.green);
                        o_fail_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $display("%0t: blue expected %0d actual %0d",
                                 $time, want.blue, got.blue);
                        o_fail_count++;
                    end
                    if (got.out_of_range !== want.out_of_range) begin
                        $display("%0t: out_of_range expected %0b actual %0b",
                                 $time, want.out_of_range, got.out_of_range);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                color_q.push_back(shade_point(i_req_data[9:0], i_req_data[19:10],
                                              area_w, area_h));
            if (i_cfg_we) begin
                if (i_cfg_index == REG_AREA_WIDTH) area_w = i_cfg_data;
                else area_h = i_cfg_data;
            end
        end
        o_pending = color_q.size();
    end

endmodule

`default_nettype wire

// ===== tb/picker_point_to_rgb_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// picker_point_to_rgb_core_test
// Drives points through the core under a series of area sizes, with random
// gaps on the request side and random backpressure on the result side; the
// checker predicts every color and this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module picker_point_to_rgb_core_test
    import pptr_pkg::*;
();

    localparam int LATENCY  = 24 + 19;
    localparam int WD_LIMIT = 4000;
    localparam int N_PHASES = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [9:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    int          fail_count;
    int          pending;
    bit          quiet;      // no idling on either side
    logic [9:0]  cur_w, cur_h;

    // area sizes per phase; phase 0 keeps the reset values
    int phase_w[N_PHASES] = '{100, 1, 1023, 7, 0, 1023, 64, 200};
    int phase_h[N_PHASES] = '{150, 2, 1023, 3, 1, 1, 1022, 37};

    picker_point_to_rgb_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    picker_point_to_rgb_core_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .i_rsp_data  (m_axis_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hold tready low in random bursts, except in the quiet tail.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
            if (idle >= WD_LIMIT) begin
                $display("picker_point_to_rgb_core_test: done, errors");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [9:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Issue one request; hold it until the core takes it.
    task automatic send_point(logic [9:0] x, logic [9:0] y);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'd0, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Wait until every predicted color is back, then let the pipe settle.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [9:0] pick(logic [9:0] lim);
        // mostly inside the area, sometimes anywhere in the field
        if (lim == 0 || $urandom_range(0, 6) == 0) return 10'($urandom_range(0, 1023));
        return 10'($urandom_range(0, lim - 1));
    endfunction

    initial begin
        logic [9:0] half;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_AREA_WIDTH;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        quiet         = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            cur_w = 10'(phase_w[ph]);
            cur_h = 10'(phase_h[ph]);
            if (ph != 0) begin
                drain();
                write_reg(REG_AREA_WIDTH, cur_w);
                write_reg(REG_AREA_HEIGHT, cur_h);
            end
            if (ph == N_PHASES - 1) quiet = 1'b1;

            // corners, sector edges, the half row, the last row, just outside
            half = cur_h >> 1;
            if (ph == 0 || ph == 3) begin
                send_point(10'd0, 10'd0);
                send_point(cur_w - 10'd1, 10'd0);
                send_point(10'd0, half);
                send_point(cur_w - 10'd1, half);
                send_point(cur_w >> 1, half + 10'd1);
                send_point(10'(cur_w / 3), cur_h - 10'd1);
                send_point(cur_w - 10'd1, cur_h - 10'd1);
                for (int s = 1; s < 6; s++) begin
                    send_point(10'((cur_w * s) / 6), half >> 1);
                    send_point(10'((cur_w * s + 5) / 6), half);
                end
                send_point(cur_w, 10'd0);
                send_point(10'd0, cur_h);
                send_point(10'd1023, 10'd1023);
                send_point(10'h155, 10'h2AA);
                send_point(10'h2AA, 10'h155);
            end

            for (int n = 0; n < 175; n++) begin
                // once, stop and let the pipe empty completely
                if (ph == 2 && n == 60) begin
                    @(negedge i_clk);
                    s_axis_tvalid = 1'b0;
                    while (pending != 0) @(posedge i_clk);
                end
                send_point(pick(cur_w), pick(cur_h));
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("picker_point_to_rgb_core_test: done, clean");
        end else begin
            $display("picker_point_to_rgb_core_test: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
